>>> hw/rtl/normalized_2d_convolution_defines.svh
// Assertion macros for the normalized 2D convolution RTL.
`ifndef NORMALIZED_2D_CONVOLUTION_DEFINES_SVH
`define NORMALIZED_2D_CONVOLUTION_DEFINES_SVH

// Check a condition at every rising clock edge outside reset.
`define NCV_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that a trigger implies a consequence in the next clock cycle.
`define NCV_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/ncv_pkg.sv
// Types and constants of the normalized 2D convolution block.
package ncv_pkg;

	localparam int CFG_W      = 13;
	localparam int RESULT_W   = 40;
	localparam int ROW_W      = 12;
	localparam int HEIGHT_W   = 13;
	localparam int IMG_H_MAX  = 4096;

	localparam logic [1:0] CFG_IMAGE_WIDTH   = 2'd0;
	localparam logic [1:0] CFG_IMAGE_HEIGHT  = 2'd1;
	localparam logic [1:0] CFG_FILTER_WIDTH  = 2'd2;
	localparam logic [1:0] CFG_FILTER_HEIGHT = 2'd3;

	localparam logic        CMD_COEF  = 1'b0;
	localparam logic        CMD_PIXEL = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic clear;
		logic en;
	} mac_ctrl_t;

endpackage

>>> hw/rtl/ncv_ram.sv
// Generic simple dual-port RAM with registered read.
module ncv_ram import ncv_pkg::*; #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1280
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/ncv_mac.sv
// Shared multiply-accumulate unit: one product per cycle, registered, then summed.
module ncv_mac import ncv_pkg::*; #(
	parameter int SB    = 16,
	parameter int ACC_W = 37
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mac_ctrl_t               ctrl,
	input  logic signed [SB-1:0]    a,
	input  logic signed [SB-1:0]    b,
	output logic signed [ACC_W-1:0] acc,
	output logic                    busy
);

	logic signed [2*SB-1:0]  prod_s2;
	logic                    val_s2;
	logic signed [ACC_W-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s2 <= 1'b0;
		end else begin
			val_s2 <= ctrl.en;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			prod_s2 <= a * b;
		end
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (val_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	assign acc  = acc_q;
	assign busy = val_s2;

endmodule

>>> hw/rtl/ncv_div.sv
// Restoring divider on magnitudes, one quotient bit per cycle.
module ncv_div import ncv_pkg::*; #(
	parameter int ACC_W = 37,
	parameter int WS_W  = 21
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [ACC_W-1:0] dividend,
	input  logic [WS_W-1:0]  divisor,
	output logic             done,
	output logic [ACC_W-1:0] quotient
);

	localparam int CNT_W = $clog2(ACC_W + 1);

	logic [ACC_W-1:0] quo_q;
	logic [WS_W-1:0]  rem_q;
	logic [WS_W-1:0]  div_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [WS_W:0]    trial;
	logic             take;

	always_comb begin
		trial = {rem_q, quo_q[ACC_W-1]};
		take  = trial >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ACC_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			// shift in the next dividend bit, subtract when it fits
			rem_q <= take ? WS_W'(trial - {1'b0, div_q}) : WS_W'(trial);
			quo_q <= {quo_q[ACC_W-2:0], take};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> hw/rtl/normalized_2d_convolution.sv
// Normalized valid-mode 2D correlation: kernel load, row stores, MAC and divide sequencer.
// Coefficient words (command 0) load the kernel in row-major order and restart the frame;
// pixel words (command 1) arrive in raster order. A coefficient word, or a pixel that
// completes no window, leaves the block idle and ready. A pixel that completes a window
// holds off further words until its result is in the output register: the sequencer
// issues one row store read and one multiply-accumulate per kernel tap, then a restoring
// divider produces one quotient bit per cycle. The row store is a single RAM of
// MAX_FILTER_SIZE rows of MAX_IMAGE_WIDTH samples and needs no clearing after reset.
// A finished result waits in the output register while the next word is accepted.
`include "normalized_2d_convolution_defines.svh"

module normalized_2d_convolution import ncv_pkg::*; #(
	parameter int MAX_IMAGE_WIDTH = 256,
	parameter int MAX_FILTER_SIZE = 5,
	parameter int SAMPLE_BITS     = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [1:0]                        cfg_addr,
	input  logic [CFG_W-1:0]                  cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              command,
	input  logic signed [SAMPLE_BITS-1:0]     value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [RESULT_W-1:0]        result_value,
	output logic [ROW_W-1:0]                  result_row,
	output logic [$clog2(MAX_IMAGE_WIDTH)-1:0] result_col,
	output logic                              divide_by_zero,
	output logic                              frame_end
);

	localparam int SB      = SAMPLE_BITS;
	localparam int MF      = MAX_FILTER_SIZE;
	localparam int K_DEPTH = MF * MF;
	localparam int KB      = $clog2(K_DEPTH);
	localparam int KI_W    = (KB < 1) ? 1 : KB;
	localparam int CC_W    = $clog2(K_DEPTH + 1);
	localparam int FS_W    = $clog2(MF + 1);
	localparam int SL_W    = ($clog2(MF) < 1) ? 1 : $clog2(MF);
	localparam int COL_W   = $clog2(MAX_IMAGE_WIDTH);
	localparam int IW_W    = $clog2(MAX_IMAGE_WIDTH + 1);
	localparam int RA_DEPTH = MF * MAX_IMAGE_WIDTH;
	localparam int RA_W    = $clog2(RA_DEPTH);
	localparam int ACC_W   = (2 * SB + KB > 64) ? 64 : 2 * SB + KB;
	localparam int WS_W    = SB + KB;
	localparam int EXT_W   = (ACC_W + 1 > RESULT_W) ? ACC_W + 1 : RESULT_W;

	// configuration
	logic [8:0]          iw_cfg_q;
	logic [12:0]         ih_cfg_q;
	logic [2:0]          fw_cfg_q;
	logic [2:0]          fh_cfg_q;
	logic [IW_W-1:0]     iw;
	logic [HEIGHT_W-1:0] ih;
	logic [FS_W-1:0]     fw;
	logic [FS_W-1:0]     fh;
	logic [CC_W-1:0]     n_taps;

	// kernel and frame position
	logic signed [SB-1:0]   coef_mem [K_DEPTH];
	logic signed [WS_W-1:0] weight_sum_q;
	logic [CC_W-1:0]        coef_count_q;
	logic [COL_W-1:0]       pixel_col_q;
	logic [ROW_W-1:0]       pixel_row_q;
	logic [SL_W-1:0]        pixel_slot_q;

	// sequencer
	state_t              state_q, state_d;
	logic [SL_W-1:0]     win_slot_q;
	logic [COL_W-1:0]    win_col0_q;
	logic [COL_W-1:0]    win_col_q;
	logic [FS_W-1:0]     tap_i_q;
	logic [CC_W-1:0]     tap_k_q;
	logic [ROW_W-1:0]    pend_row_q;
	logic [COL_W-1:0]    pend_col_q;
	logic                pend_last_q;
	logic                pend_dz_q;
	logic                pend_neg_q;
	logic [RESULT_W-1:0] pend_value_q;
	logic                valid_s1;
	logic signed [SB-1:0] coef_s1;

	// output register
	logic                out_valid_q;
	logic [RESULT_W-1:0] res_value_q;
	logic [ROW_W-1:0]    res_row_q;
	logic [COL_W-1:0]    res_col_q;
	logic                res_dz_q;
	logic                res_last_q;

	// pixel step
	logic [COL_W-1:0]    c_cur;
	logic [HEIGHT_W-1:0] r_cur;
	logic [SL_W-1:0]     s_cur;
	logic [COL_W-1:0]    c_next;
	logic [ROW_W-1:0]    r_next;
	logic [SL_W-1:0]     s_next;
	logic                fire;
	logic                last_px;
	logic [SL_W-1:0]     start_slot;

	logic                accept;
	logic                issue;
	logic                issue_last;
	logic                out_free;
	logic                div_start;
	logic                div_done;
	logic [ACC_W-1:0]    div_quo;
	logic [RA_W-1:0]     waddr;
	logic [RA_W-1:0]     raddr;
	logic [SB-1:0]       rdata;
	mac_ctrl_t           mac_ctrl;
	logic signed [ACC_W-1:0] acc;
	logic                mac_busy;
	logic [ACC_W-1:0]    acc_mag;
	logic [WS_W-1:0]     ws_mag;
	logic [EXT_W-1:0]    q_ext;
	logic [CC_W-1:0]     cnt_eff;
	logic signed [WS_W-1:0] ws_base;

	function automatic logic [SL_W-1:0] slot_inc(input logic [SL_W-1:0] s);
		return (int'(s) == MF - 1) ? '0 : SL_W'(int'(s) + 1);
	endfunction

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;

	// saturate registers to their legal ranges
	always_comb begin
		if (iw_cfg_q == '0) begin
			iw = IW_W'(1);
		end else if (int'(iw_cfg_q) > MAX_IMAGE_WIDTH) begin
			iw = IW_W'(MAX_IMAGE_WIDTH);
		end else begin
			iw = IW_W'(iw_cfg_q);
		end
		if (ih_cfg_q == '0) begin
			ih = HEIGHT_W'(1);
		end else if (int'(ih_cfg_q) > IMG_H_MAX) begin
			ih = HEIGHT_W'(IMG_H_MAX);
		end else begin
			ih = HEIGHT_W'(ih_cfg_q);
		end
		if (fw_cfg_q == '0) begin
			fw = FS_W'(1);
		end else if (int'(fw_cfg_q) > MF) begin
			fw = FS_W'(MF);
		end else begin
			fw = FS_W'(fw_cfg_q);
		end
		if (fh_cfg_q == '0) begin
			fh = FS_W'(1);
		end else if (int'(fh_cfg_q) > MF) begin
			fh = FS_W'(MF);
		end else begin
			fh = FS_W'(fh_cfg_q);
		end
		n_taps = CC_W'(int'(fw) * int'(fh));
	end

	// position of the incoming pixel and of the one after it
	always_comb begin
		c_cur = pixel_col_q;
		r_cur = HEIGHT_W'(pixel_row_q);
		s_cur = pixel_slot_q;
		if (IW_W'(pixel_col_q) >= iw) begin
			c_cur = '0;
			r_cur = r_cur + 1'b1;
			s_cur = slot_inc(pixel_slot_q);
		end
		if (r_cur >= ih) begin
			r_cur = '0;
			s_cur = '0;
		end
		c_next = COL_W'(int'(c_cur) + 1);
		r_next = ROW_W'(r_cur);
		s_next = s_cur;
		if (IW_W'(int'(c_cur) + 1) >= iw) begin
			c_next = '0;
			if (int'(r_cur) + 1 >= int'(ih)) begin
				r_next = '0;
				s_next = '0;
			end else begin
				r_next = ROW_W'(int'(r_cur) + 1);
				s_next = slot_inc(s_cur);
			end
		end
		last_px = (int'(r_cur) == int'(ih) - 1) && (int'(c_cur) == int'(iw) - 1);
		fire    = (coef_count_q == n_taps) && (int'(r_cur) + 1 >= int'(fh))
			&& (int'(c_cur) + 1 >= int'(fw));
		if (int'(s_cur) + MF + 1 - int'(fh) >= MF) begin
			start_slot = SL_W'(int'(s_cur) + 1 - int'(fh));
		end else begin
			start_slot = SL_W'(int'(s_cur) + MF + 1 - int'(fh));
		end
		waddr = RA_W'(int'(s_cur) * MAX_IMAGE_WIDTH + int'(c_cur));
		raddr = RA_W'(int'(win_slot_q) * MAX_IMAGE_WIDTH + int'(win_col_q));
	end

	always_comb begin
		cnt_eff = (coef_count_q >= n_taps) ? '0 : coef_count_q;
		ws_base = (coef_count_q >= n_taps) ? '0 : weight_sum_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iw_cfg_q <= 9'd8;
			ih_cfg_q <= 13'd8;
			fw_cfg_q <= 3'd3;
			fh_cfg_q <= 3'd3;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_IMAGE_WIDTH:   iw_cfg_q <= cfg_data[8:0];
				CFG_IMAGE_HEIGHT:  ih_cfg_q <= cfg_data[12:0];
				CFG_FILTER_WIDTH:  fw_cfg_q <= cfg_data[2:0];
				CFG_FILTER_HEIGHT: fh_cfg_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_sum_q <= '0;
			coef_count_q <= '0;
			pixel_col_q  <= '0;
			pixel_row_q  <= '0;
			pixel_slot_q <= '0;
		end else if (accept) begin
			if (command == CMD_COEF) begin
				weight_sum_q <= ws_base + WS_W'(value);
				coef_count_q <= cnt_eff + 1'b1;
				pixel_col_q  <= '0;
				pixel_row_q  <= '0;
				pixel_slot_q <= '0;
			end else begin
				pixel_col_q  <= c_next;
				pixel_row_q  <= r_next;
				pixel_slot_q <= s_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && command == CMD_COEF) begin
			coef_mem[cnt_eff[KI_W-1:0]] <= value;
		end
	end

	ncv_ram #(
		.WIDTH (SB),
		.DEPTH (RA_DEPTH)
	) u_row_ram (
		.clk   (clk),
		.we    (accept && command == CMD_PIXEL),
		.waddr (waddr),
		.wdata (value),
		.re    (issue),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign issue      = (state_q == ST_MAC);
	assign issue_last = issue && (tap_k_q == n_taps - 1'b1);

	always_comb begin
		mac_ctrl.clear = accept && command == CMD_PIXEL && fire;
		mac_ctrl.en    = valid_s1;
	end

	ncv_mac #(
		.SB    (SB),
		.ACC_W (ACC_W)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.a      (signed'(rdata)),
		.b      (coef_s1),
		.acc    (acc),
		.busy   (mac_busy)
	);

	always_comb begin
		acc_mag   = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
		ws_mag    = weight_sum_q[WS_W-1] ? WS_W'(-weight_sum_q) : WS_W'(weight_sum_q);
		div_start = (state_q == ST_DRAIN) && !valid_s1 && !mac_busy
			&& (weight_sum_q != '0);
		q_ext     = pend_neg_q ? -EXT_W'({1'b0, div_quo}) : EXT_W'({1'b0, div_quo});
	end

	ncv_div #(
		.ACC_W (ACC_W),
		.WS_W  (WS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (acc_mag),
		.divisor  (ws_mag),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && command == CMD_PIXEL && fire) begin
					state_d = ST_MAC;
				end
			end
			ST_MAC: begin
				if (issue_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!valid_s1 && !mac_busy) begin
					state_d = (weight_sum_q == '0) ? ST_OUT : ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= issue;
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && command == CMD_PIXEL && fire) begin
			win_slot_q  <= start_slot;
			win_col0_q  <= COL_W'(int'(c_cur) + 1 - int'(fw));
			win_col_q   <= COL_W'(int'(c_cur) + 1 - int'(fw));
			tap_i_q     <= '0;
			tap_k_q     <= '0;
			pend_row_q  <= ROW_W'(int'(r_cur) + 1 - int'(fh));
			pend_col_q  <= COL_W'(int'(c_cur) + 1 - int'(fw));
			pend_last_q <= last_px;
		end
		if (issue) begin
			coef_s1 <= coef_mem[tap_k_q[KI_W-1:0]];
			tap_k_q <= tap_k_q + 1'b1;
			// advance across the window row, then to the next stored row
			if (tap_i_q == fw - 1'b1) begin
				tap_i_q    <= '0;
				win_col_q  <= win_col0_q;
				win_slot_q <= slot_inc(win_slot_q);
			end else begin
				tap_i_q   <= tap_i_q + 1'b1;
				win_col_q <= win_col_q + 1'b1;
			end
		end
		if (state_q == ST_DRAIN && !valid_s1 && !mac_busy) begin
			pend_neg_q   <= acc[ACC_W-1] ^ weight_sum_q[WS_W-1];
			pend_dz_q    <= (weight_sum_q == '0);
			pend_value_q <= '0;
		end
		if (state_q == ST_DIV && div_done) begin
			pend_value_q <= q_ext[RESULT_W-1:0];
		end
		if (state_q == ST_OUT && out_free) begin
			res_value_q <= pend_value_q;
			res_row_q   <= pend_row_q;
			res_col_q   <= pend_col_q;
			res_dz_q    <= pend_dz_q;
			res_last_q  <= pend_last_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign result_value   = signed'(res_value_q);
	assign result_row     = res_row_q;
	assign result_col     = res_col_q;
	assign divide_by_zero = res_dz_q;
	assign frame_end      = res_last_q;

	`NCV_ASSERT(a_div_done_in_div, !div_done || state_q == ST_DIV, "divide done outside divide")
	`NCV_ASSERT(a_idle_drained, !in_ready || (!valid_s1 && !mac_busy), "MAC busy while idle")
	`NCV_ASSERT(a_coef_count_range, int'(coef_count_q) <= K_DEPTH, "coefficient count too large")
	`NCV_ASSERT_NEXT(a_fire_starts_mac, accept && command == CMD_PIXEL && fire,
		state_q == ST_MAC, "window did not start MAC")

endmodule

>>> tb/tb_normalized_2d_convolution.sv
// Testbench for the normalized 2D convolution block: directed and random frames, self-checked.
`timescale 1ns / 1ps

module tb_normalized_2d_convolution;
	import ncv_pkg::*;

	localparam int IMG_W_MAX  = 256;
	localparam int FILT_MAX   = 5;
	localparam int KERN_DEPTH = FILT_MAX * FILT_MAX;
	localparam int IDLE_LIMIT = 5000;
	localparam int SETTLE     = 100;

	typedef struct packed {
		logic signed [RESULT_W-1:0] value;
		logic [ROW_W-1:0]           row;
		logic [7:0]                 col;
		logic                       dz;
		logic                       fe;
	} conv_result_t;

	logic                     clk;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [1:0]               cfg_addr = CFG_IMAGE_WIDTH;
	logic [CFG_W-1:0]         cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic                     command = CMD_COEF;
	logic signed [15:0]       value = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [RESULT_W-1:0] result_value;
	logic [ROW_W-1:0]         result_row;
	logic [7:0]               result_col;
	logic                     divide_by_zero;
	logic                     frame_end;

	normalized_2d_convolution u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .command(command), .value(value),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_value(result_value), .result_row(result_row), .result_col(result_col),
		.divide_by_zero(divide_by_zero), .frame_end(frame_end)
	);

	// model state of the block
	logic [8:0]         img_w_reg;
	logic [12:0]        img_h_reg;
	logic [2:0]         filt_w_reg, filt_h_reg;
	logic signed [15:0] kern [KERN_DEPTH];
	logic signed [15:0] line_buf [FILT_MAX * IMG_W_MAX];
	longint             weight_sum;
	int                 coef_count, pix_col, pix_row;

	conv_result_t pending_results[$];
	int  errors = 0;
	int  idle_cycles = 0;
	int  hold_off = 0;
	bit  burst = 0;
	int  random_words = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int clamp_range(int v, int hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	task automatic predict_word(input logic cmd, input logic signed [15:0] val);
		int iw, ih, fw, fh, n, r, c, slot;
		longint acc, q;
		conv_result_t res;
		iw = clamp_range(img_w_reg, IMG_W_MAX);
		ih = clamp_range(img_h_reg, IMG_H_MAX);
		fw = clamp_range(filt_w_reg, FILT_MAX);
		fh = clamp_range(filt_h_reg, FILT_MAX);
		n = fw * fh;
		if (cmd == CMD_COEF) begin
			if (coef_count >= n) begin
				coef_count = 0;
				weight_sum = 0;
			end
			kern[coef_count % KERN_DEPTH] = val;
			weight_sum += longint'(val);
			coef_count++;
			pix_col = 0;
			pix_row = 0;
			return;
		end
		if (pix_col >= iw) begin
			pix_col = 0;
			pix_row++;
		end
		if (pix_row >= ih) pix_row = 0;
		r = pix_row;
		c = pix_col;
		line_buf[(r % FILT_MAX) * IMG_W_MAX + c] = val;
		pix_col = c + 1;
		if (pix_col >= iw) begin
			pix_col = 0;
			pix_row = (r + 1 >= ih) ? 0 : r + 1;
		end
		if (coef_count != n || r + 1 < fh || c + 1 < fw) return;
		acc = 0;
		for (int j = 0; j < fh; j++) begin
			slot = ((r + 1 - fh + j) % FILT_MAX) * IMG_W_MAX;
			for (int i = 0; i < fw; i++)
				acc += longint'(kern[(j * fw + i) % KERN_DEPTH]) *
					longint'(line_buf[slot + c + 1 - fw + i]);
		end
		if (weight_sum == 0) begin
			res.value = '0;
			res.dz = 1'b1;
		end else begin
			q = acc / weight_sum;
			res.value = q[RESULT_W-1:0];
			res.dz = 1'b0;
		end
		res.row = ROW_W'(r + 1 - fh);
		res.col = 8'(c + 1 - fw);
		res.fe = (r == ih - 1) && (c == iw - 1);
		pending_results.push_back(res);
	endtask

	// Call at a rising edge; returns at the edge that accepts the word.
	task automatic send_word(input logic cmd, input logic signed [15:0] val);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		value <= val;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		predict_word(cmd, val);
	endtask

	function automatic logic signed [15:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic signed [15:0] rand_coef();
		if ($urandom_range(0, 9) == 0) return rand_sample();
		return 16'($signed($urandom_range(0, 20)) - 5);
	endfunction

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_config(input int iw, input int ih, input int fw, input int fh);
		logic [CFG_W-1:0] vals [4];
		logic [1:0] addrs [4];
		vals = '{CFG_W'(iw), CFG_W'(ih), CFG_W'(fw), CFG_W'(fh)};
		addrs = '{CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT, CFG_FILTER_WIDTH, CFG_FILTER_HEIGHT};
		for (int k = 0; k < 4; k++) begin
			cfg_we <= 1'b1;
			cfg_addr <= addrs[k];
			cfg_data <= vals[k];
			@(posedge clk);
			case (addrs[k])
				CFG_IMAGE_WIDTH:  img_w_reg = vals[k][8:0];
				CFG_IMAGE_HEIGHT: img_h_reg = vals[k][12:0];
				CFG_FILTER_WIDTH: filt_w_reg = vals[k][2:0];
				default:          filt_h_reg = vals[k][2:0];
			endcase
		end
		cfg_we <= 1'b0;
	endtask

	task automatic load_kernel(input int n, input bit zero_sum);
		logic signed [15:0] k;
		longint s;
		s = 0;
		for (int i = 0; i < n; i++) begin
			k = rand_coef();
			if (zero_sum && i == n - 1) k = 16'(-s);
			s += longint'(k);
			send_word(CMD_COEF, k);
		end
	endtask

	task automatic send_pixels(input int count);
		repeat (count) send_word(CMD_PIXEL, rand_sample());
	endtask

	task automatic test_defaults();
		send_word(CMD_COEF, 16'sh7fff);
		send_word(CMD_COEF, 16'sh8000);
		load_kernel(7, 0);
		send_pixels(72);
		wait_idle();
	endtask

	task automatic test_partial_kernel();
		set_config(4, 3, 2, 2);
		load_kernel(2, 0);
		send_pixels(6);
		load_kernel(2, 0);
		send_pixels(14);
		wait_idle();
	endtask

	task automatic test_zero_sum();
		set_config(4, 2, 2, 1);
		send_word(CMD_COEF, 16'sd1);
		send_word(CMD_COEF, -16'sd1);
		send_pixels(10);
		wait_idle();
	endtask

	task automatic test_oversized_filter();
		set_config(2, 2, 3, 3);
		load_kernel(9, 0);
		send_pixels(6);
		wait_idle();
	endtask

	task automatic test_clamped_regs();
		set_config(0, 0, 0, 0);
		load_kernel(1, 0);
		send_pixels(4);
		wait_idle();
		set_config(9'h1ff, 13'h1fff, 7, 6);
		load_kernel(25, 0);
		send_pixels(IMG_W_MAX * 4 + 12);
		wait_idle();
		set_config(3, 5, 1, 5);
		load_kernel(5, 0);
		send_pixels(20);
		wait_idle();
	endtask

	// Shrink the image in the middle of a frame; every store slot was filled by a full frame.
	task automatic test_shrink_midframe();
		set_config(8, 8, 3, 3);
		load_kernel(9, 0);
		send_pixels(8 * 8 + 20);
		wait_idle();
		set_config(5, 6, 3, 3);
		send_pixels(60);
		wait_idle();
	endtask

	task automatic test_backpressure();
		set_config(6, 6, 2, 2);
		load_kernel(4, 0);
		burst = 1;
		hold_off = 400;
		send_pixels(60);
		burst = 0;
		wait_idle();
	endtask

	task automatic test_random();
		int iw, ih, fw, fh, len;
		while (random_words < 300) begin
			fw = $urandom_range(1, 5);
			fh = $urandom_range(1, 5);
			if ($urandom_range(0, 7) == 0) iw = $urandom_range(200, 256);
			else iw = $urandom_range(1, 12);
			ih = $urandom_range(1, 10);
			set_config(iw, ih, fw, fh);
			burst = ($urandom_range(0, 3) == 0);
			load_kernel(fw * fh, $urandom_range(0, 5) == 0);
			len = $urandom_range(40, 150);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 19) == 0) send_word(CMD_COEF, rand_coef());
				else send_word(CMD_PIXEL, rand_sample());
			end
			random_words += fw * fh + len;
			burst = 0;
			wait_idle();
		end
	endtask

	// receiver: random stalls, and one long hold when requested
	initial begin : receiver
		int w;
		@(posedge arst_n);
		forever begin
			if (hold_off > 0) begin
				w = hold_off;
				hold_off = 0;
			end else begin
				w = burst ? 0 : $urandom_range(0, 11);
			end
			if (w > 0) begin
				out_ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(negedge clk); while (!out_valid);
			@(posedge clk);
		end
	end

	// check each result word and watch for a hang
	always @(negedge clk) begin
		conv_result_t exp_res;
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
			else idle_cycles++;
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					errors++;
					$display("%0t: result expected none actual %0d", $time, result_value);
				end else begin
					exp_res = pending_results.pop_front();
					if (result_value !== exp_res.value) begin
						errors++;
						$display("%0t: result_value expected %0d actual %0d",
							$time, exp_res.value, result_value);
					end
					if (result_row !== exp_res.row) begin
						errors++;
						$display("%0t: result_row expected %0d actual %0d",
							$time, exp_res.row, result_row);
					end
					if (result_col !== exp_res.col) begin
						errors++;
						$display("%0t: result_col expected %0d actual %0d",
							$time, exp_res.col, result_col);
					end
					if (divide_by_zero !== exp_res.dz) begin
						errors++;
						$display("%0t: divide_by_zero expected %0b actual %0b",
							$time, exp_res.dz, divide_by_zero);
					end
					if (frame_end !== exp_res.fe) begin
						errors++;
						$display("%0t: frame_end expected %0b actual %0b",
							$time, exp_res.fe, frame_end);
					end
				end
			end
			if (idle_cycles > IDLE_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin : main
		img_w_reg = 9'd8;
		img_h_reg = 13'd8;
		filt_w_reg = 3'd3;
		filt_h_reg = 3'd3;
		weight_sum = 0;
		coef_count = 0;
		pix_col = 0;
		pix_row = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_partial_kernel();
		test_zero_sum();
		test_oversized_filter();
		test_clamped_regs();
		test_shrink_midframe();
		test_backpressure();
		test_random();
		wait_idle();
		if (errors == 0 && pending_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
